// ----- rtl/tcw_pkg.sv -----
// Shared constants, request codes and controller/datapath interface types
// for the text console writer. No dependencies.
package tcw_pkg;

   localparam int COLS      = 80;
   localparam int ROWS      = 25;
   localparam int NCELLS    = COLS * ROWS;
   localparam int RESET_ROW = (5 < ROWS) ? 5 : ROWS - 1;

   localparam int IDX_W  = $clog2(NCELLS);
   localparam int CNT_W  = $clog2(NCELLS + 1);
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;
   localparam int CLR_W  = 4;

   localparam int IN_DATA_W  = 24;
   localparam int IN_USER_W  = 2;
   localparam int OUT_DATA_W = 40;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_SET   = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic REG_FG = 1'b0;
   localparam logic REG_BG = 1'b1;
   localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
   localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

   typedef struct packed {
      logic latch_req;
      logic exec;
      logic cnt_clear;
      logic fill_blank;
      logic scroll_step;
      logic out_load;
   } tcw_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       scroll_needed;
      logic       fill_done;
      logic       scroll_done;
      logic       out_busy;
   } tcw_status_type;

endpackage

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine for the text console writer: sequences init
// clear, request execution, screen sweeps and result hand-off. Uses tcw_pkg.
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output tcw_pkg::tcw_cmd_type    cmd,
   input  tcw_pkg::tcw_status_type status
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_blank = 1'b1;
            if (status.fill_done) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.kind == tcw_pkg::REQ_CLEAR) begin
               state_in = ST_CLEAR;
            end else if (status.scroll_needed) begin
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.fill_blank = 1'b1;
            if (status.fill_done) begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output slot to free up
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/tcw_dp.sv -----
// Datapath for the text console writer: colour registers, cursor, sweep
// counter, screen RAM and output register. Uses tcw_pkg and tcw_ram.
module tcw_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  tcw_pkg::tcw_cmd_type              cmd,
   output tcw_pkg::tcw_status_type           status,
   input  logic [tcw_pkg::IN_DATA_W-1:0]    req_tdata,
   input  logic [tcw_pkg::IN_USER_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcw_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcw_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [tcw_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [tcw_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = tcw_pkg::IDX_W;
   localparam int CNT_W = tcw_pkg::CNT_W;
   localparam int COL_W = tcw_pkg::COL_W;
   localparam int ROW_W = tcw_pkg::ROW_W;
   localparam int CLR_W = tcw_pkg::CLR_W;

   // colour registers
   logic [CLR_W-1:0] fg_ff, fg_in, bg_ff, bg_in;
   logic             csr_wr;
   logic             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[tcw_pkg::CSR_AW-1];

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wr) begin
         case (csr_idx)
            tcw_pkg::REG_FG: fg_in = csr_pwdata[CLR_W-1:0];
            tcw_pkg::REG_BG: bg_in = csr_pwdata[CLR_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_prdata = (csr_idx == tcw_pkg::REG_BG) ? tcw_pkg::CSR_DW'(bg_ff)
                                                     : tcw_pkg::CSR_DW'(fg_ff);

   // latched request
   logic [1:0] kind_ff;
   logic [7:0] ch_ff, col_ff, row_ff;

   // cursor and per-request flags
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic             scroll_ff, hit_ff;
   logic             need_scroll, rd_hit;
   logic [IDX_W-1:0] cur_idx, req_idx;
   logic             req_in_range;

   // sweep counter
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_prev;
   logic             copy_phase;

   // RAM ports
   logic                        ram_we, ram_re;
   logic [IDX_W-1:0]            ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

   assign cur_idx = IDX_W'(y_ff) * IDX_W'(tcw_pkg::COLS) + IDX_W'(x_ff);
   assign req_in_range = (int'(col_ff) < tcw_pkg::COLS) && (int'(row_ff) < tcw_pkg::ROWS);
   assign req_idx = IDX_W'(row_ff[ROW_W-1:0]) * IDX_W'(tcw_pkg::COLS)
                  + IDX_W'(col_ff[COL_W-1:0]);
   assign cnt_prev   = cnt_ff - CNT_W'(1);
   assign copy_phase = cnt_prev < CNT_W'(tcw_pkg::NCELLS - tcw_pkg::COLS);

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      need_scroll = 1'b0;
      rd_hit      = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = cur_idx;
      ram_wdata   = {bg_ff, fg_ff, ch_ff};
      ram_re      = 1'b0;
      ram_raddr   = req_idx;
      if (cmd.exec) begin
         case (kind_ff)
            tcw_pkg::REQ_PUT: begin
               case (ch_ff)
                  tcw_pkg::CH_CR: x_in = '0;
                  tcw_pkg::CH_LF: begin
                     if (y_ff == ROW_W'(tcw_pkg::ROWS - 1)) begin
                        need_scroll = 1'b1;
                     end else begin
                        y_in = y_ff + ROW_W'(1);
                     end
                  end
                  tcw_pkg::CH_BS: begin
                     // stays put at the top-left corner
                     if (x_ff != '0) begin
                        x_in = x_ff - COL_W'(1);
                     end else if (y_ff != '0) begin
                        x_in = COL_W'(tcw_pkg::COLS - 1);
                        y_in = y_ff - ROW_W'(1);
                     end
                  end
                  default: begin
                     ram_we = 1'b1;
                     if (x_ff == COL_W'(tcw_pkg::COLS - 1)) begin
                        x_in = '0;
                        if (y_ff == ROW_W'(tcw_pkg::ROWS - 1)) begin
                           need_scroll = 1'b1;
                        end else begin
                           y_in = y_ff + ROW_W'(1);
                        end
                     end else begin
                        x_in = x_ff + COL_W'(1);
                     end
                  end
               endcase
            end
            tcw_pkg::REQ_CLEAR: begin
               x_in = '0;
               y_in = '0;
            end
            tcw_pkg::REQ_SET: begin
               if (req_in_range) begin
                  x_in = col_ff[COL_W-1:0];
                  y_in = row_ff[ROW_W-1:0];
               end
            end
            tcw_pkg::REQ_READ: begin
               rd_hit = req_in_range;
               ram_re = req_in_range;
            end
            default: ;
         endcase
      end else if (cmd.fill_blank) begin
         ram_we    = 1'b1;
         ram_waddr = IDX_W'(cnt_ff);
         ram_wdata = tcw_pkg::BLANK_CELL;
      end else if (cmd.scroll_step) begin
         // read row below at cnt, write previous read to cnt-1; last row blank
         ram_re    = cnt_ff < CNT_W'(tcw_pkg::NCELLS - tcw_pkg::COLS);
         ram_raddr = IDX_W'(cnt_ff) + IDX_W'(tcw_pkg::COLS);
         ram_we    = cnt_ff != '0;
         ram_waddr = IDX_W'(cnt_prev);
         ram_wdata = copy_phase ? ram_rdata : {bg_ff, fg_ff, tcw_pkg::CH_SPACE};
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.fill_blank || cmd.scroll_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(tcw_pkg::NCELLS)
   ) u_screen (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // output register
   logic                          out_valid_ff, out_valid_in;
   logic [tcw_pkg::OUT_DATA_W-1:0] out_data_ff;
   logic [tcw_pkg::CELL_W-1:0]     cell_val;

   assign cell_val = (kind_ff == tcw_pkg::REQ_READ && hit_ff) ? ram_rdata : '0;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= tcw_pkg::FG_RESET;
         bg_ff        <= tcw_pkg::BG_RESET;
         x_ff         <= '0;
         y_ff         <= ROW_W'(tcw_pkg::RESET_ROW);
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff <= req_tuser;
         ch_ff   <= req_tdata[7:0];
         col_ff  <= req_tdata[15:8];
         row_ff  <= req_tdata[23:16];
      end
      if (cmd.exec) begin
         scroll_ff <= need_scroll;
         hit_ff    <= rd_hit;
      end
      if (cmd.out_load) begin
         out_data_ff <= {scroll_ff, cell_val, y_ff, x_ff, cur_idx};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign status.kind          = kind_ff;
   assign status.scroll_needed = need_scroll;
   assign status.fill_done     = cnt_ff == CNT_W'(tcw_pkg::NCELLS - 1);
   assign status.scroll_done   = cnt_ff == CNT_W'(tcw_pkg::NCELLS);
   assign status.out_busy      = out_valid_ff & ~rsp_tready;

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Top level of the text console writer: joins controller and datapath.
// Uses tcw_pkg, tcw_ctrl, tcw_dp (and tcw_ram through tcw_dp).
//
//   Channel  | Direction | Handshake         | Payload
//   req_     | in        | tvalid / tready   | tuser: req_type; tdata: char, col, row
//   rsp_     | out       | tvalid / tready   | tdata: index, col, row, cell, scroll
//   csr_     | in        | psel/penable/pwrite | fg_color at 0x0, bg_color at 0x4
//
// Put character, set cursor and read cell each pass through accept, execute and
// result load. Clear and a put that scrolls both sweep the screen RAM one cell per cycle
// through its single write port. After reset a clearing pass runs before the first
// request is taken. The result register lets a new request be accepted while a
// result waits; a result that finds the register still full holds until it is taken.
module text_console_writer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] char_code, [15:8] col, [23:16] row
   input  logic [tcw_pkg::IN_DATA_W-1:0]    req_tdata,
   // [1:0] req_type
   input  logic [tcw_pkg::IN_USER_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [10:0] cursor_index, [17:11] cursor_col, [22:18] cursor_row,
   // [38:23] cell_data, [39] did_scroll
   output logic [tcw_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcw_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [tcw_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [tcw_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   tcw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

endmodule

// ----- rtl/tcw_checker.sv -----
// Port-level checks for text_console_writer_core, attached with bind.
// Uses tcw_pkg.
module tcw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tcw_pkg::OUT_DATA_W-1:0]   rsp_tdata
);

   // stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[17:11]) < tcw_pkg::COLS)
                  && (int'(rsp_tdata[22:18]) < tcw_pkg::ROWS))
      else $error("cursor out of screen");

   a_cursor_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[10:0])
                     == int'(rsp_tdata[22:18]) * tcw_pkg::COLS + int'(rsp_tdata[17:11]))
      else $error("cursor index does not match row and column");

   // a scroll always leaves the cursor on the bottom row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> int'(rsp_tdata[22:18]) == tcw_pkg::ROWS - 1)
      else $error("scroll with cursor off the bottom row");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

// ----- dv/text_console_writer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_core: directed table, then random requests
// in four colour settings, every result checked against the typed table row or a
// cycle-free screen/cursor model. Depends on tcw_pkg and the RTL under rtl/.
module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS = 100;
   localparam logic [CSR_AW-1:0] CSR_FG_ADDR = 3'h0;
   localparam logic [CSR_AW-1:0] CSR_BG_ADDR = 3'h4;
   localparam logic TYPED = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // same layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic        scrolled;
      logic [15:0] cell_word;
      logic [4:0]  row;
      logic [6:0]  col;
      logic [10:0] index;
   } cursor_report_t;

   typedef struct packed {
      logic [1:0]     kind;
      logic [7:0]     ch;
      logic [7:0]     c;
      logic [7:0]     r;
      logic           typed;
      cursor_report_t want;
   } step_row_t;

   localparam int NSTEPS = 26;
   localparam step_row_t SCRIPT [NSTEPS] = '{
      {REQ_READ,  8'h00, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0720, 5'd5,  7'd0,  11'd400},
      {REQ_READ,  8'h00, 8'd255, 8'd255, TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_READ,  8'h00, 8'd79,  8'd24,  TYPED, 1'b0, 16'h0720, 5'd5,  7'd0,  11'd400},
      {REQ_READ,  8'h00, 8'd80,  8'd0,   TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_READ,  8'h00, 8'd0,   8'd25,  TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_SET,   8'h00, 8'd255, 8'd255, TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_SET,   8'h00, 8'd80,  8'd0,   TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_SET,   8'h00, 8'd0,   8'd25,  TYPED, 1'b0, 16'h0000, 5'd5,  7'd0,  11'd400},
      {REQ_SET,   8'h00, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd0,  11'd0},
      {REQ_PUT,   CH_BS, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd0,  11'd0},
      {REQ_PUT,   8'h41, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_PUT,   8'hFF, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_PUT,   8'h00, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_PUT,   CH_CR, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd0,  11'd0},
      {REQ_PUT,   CH_LF, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd1,  7'd0,  11'd80},
      {REQ_PUT,   CH_BS, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd79, 11'd79},
      {REQ_READ,  8'h00, 8'd1,   8'd0,   PREDICTED, 40'd0},
      {REQ_SET,   8'h00, 8'd79,  8'd24,  TYPED, 1'b0, 16'h0000, 5'd24, 7'd79, 11'd1999},
      {REQ_PUT,   8'h5A, 8'd0,   8'd0,   TYPED, 1'b1, 16'h0000, 5'd24, 7'd0,  11'd1920},
      {REQ_READ,  8'h00, 8'd79,  8'd23,  PREDICTED, 40'd0},
      {REQ_READ,  8'h00, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_PUT,   CH_LF, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_SET,   8'h00, 8'd79,  8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd79, 11'd79},
      {REQ_PUT,   8'h7E, 8'd0,   8'd0,   PREDICTED, 40'd0},
      {REQ_CLEAR, 8'h00, 8'd0,   8'd0,   TYPED, 1'b0, 16'h0000, 5'd0,  7'd0,  11'd0},
      {REQ_READ,  8'h00, 8'd79,  8'd23,  TYPED, 1'b0, 16'h0720, 5'd0,  7'd0,  11'd0}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic [IN_USER_W-1:0]  req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   text_console_writer_core dut (.*);

   // screen and cursor as the block should hold them
   logic [CELL_W-1:0] screen_img [NCELLS];
   int                cur_x;
   int                cur_y;
   logic [CLR_W-1:0]  ink_fg;
   logic [CLR_W-1:0]  ink_bg;

   cursor_report_t pending_reports [$];
   int             mismatches = 0;
   int             cycles = 0;
   bit             gaps_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic console_apply(input logic [1:0] kind, input logic [7:0] ch,
                                input logic [7:0] c, input logic [7:0] r,
                                output cursor_report_t rpt);
      int i;
      rpt = '0;
      case (kind)
         REQ_PUT: begin
            if (ch == CH_CR) begin
               cur_x = 0;
            end else if (ch == CH_LF) begin
               cur_y++;
            end else if (ch == CH_BS) begin
               if (cur_x != 0) begin
                  cur_x--;
               end else if (cur_y != 0) begin
                  cur_y--;
                  cur_x = COLS - 1;
               end
            end else begin
               screen_img[cur_y * COLS + cur_x] = {ink_bg, ink_fg, ch};
               cur_x++;
               if (cur_x >= COLS) begin
                  cur_x = 0;
                  cur_y++;
               end
            end
            if (cur_y >= ROWS) begin
               for (i = 0; i < NCELLS - COLS; i++)
                  screen_img[i] = screen_img[i + COLS];
               for (i = NCELLS - COLS; i < NCELLS; i++)
                  screen_img[i] = {ink_bg, ink_fg, CH_SPACE};
               cur_y = ROWS - 1;
               rpt.scrolled = 1'b1;
            end
         end
         REQ_CLEAR: begin
            for (i = 0; i < NCELLS; i++)
               screen_img[i] = BLANK_CELL;
            cur_x = 0;
            cur_y = 0;
         end
         REQ_SET: begin
            if (c < COLS && r < ROWS) begin
               cur_x = int'(c);
               cur_y = int'(r);
            end
         end
         default: begin
            if (c < COLS && r < ROWS)
               rpt.cell_word = screen_img[r * COLS + c];
         end
      endcase
      rpt.index = 11'(cur_y * COLS + cur_x);
      rpt.col = 7'(cur_x);
      rpt.row = 5'(cur_y);
   endtask

   task automatic push_request(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [7:0] c, input logic [7:0] r,
                               input logic typed, input cursor_report_t want);
      cursor_report_t rpt;
      if (gaps_on && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {r, c, ch};
      do @(posedge clock); while (!req_tready);
      console_apply(kind, ch, c, r, rpt);
      pending_reports.push_back(typed ? want : rpt);
   endtask

   task automatic random_request(output logic [1:0] kind, output logic [7:0] ch,
                                 output logic [7:0] c, output logic [7:0] r);
      int pick;
      pick = $urandom_range(99);
      ch = 8'($urandom);
      c = 8'($urandom);
      r = 8'($urandom);
      if (pick < 2) begin
         kind = REQ_CLEAR;
      end else if (pick < 20) begin
         kind = REQ_SET;
         if ($urandom_range(9) != 0) begin
            c = 8'($urandom_range(COLS - 1));
            // bias toward the bottom rows so line feeds and wraps scroll
            r = ($urandom_range(2) == 0) ? 8'($urandom_range(ROWS - 1, ROWS - 2))
                                         : 8'($urandom_range(ROWS - 1));
         end
      end else if (pick < 42) begin
         kind = REQ_READ;
         if ($urandom_range(9) != 0) begin
            c = 8'($urandom_range(COLS - 1));
            r = 8'($urandom_range(ROWS - 1));
         end
      end else begin
         kind = REQ_PUT;
         case ($urandom_range(9))
            0: ch = CH_CR;
            1: ch = CH_LF;
            2: ch = CH_BS;
            default: ;
         endcase
      end
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == CSR_FG_ADDR)
         ink_fg = value[CLR_W-1:0];
      else
         ink_bg = value[CLR_W-1:0];
   endtask

   // drop valid and wait until every transfer in flight has come back
   task automatic settle;
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock)
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 15);

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      cursor_report_t got;
      cursor_report_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = cursor_report_t'(rsp_tdata);
         if (pending_reports.size() == 0) begin
            $display("%0t: expected no transfer, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("cursor_index", 32'(want.index), 32'(got.index));
            check_field("cursor_col", 32'(want.col), 32'(got.col));
            check_field("cursor_row", 32'(want.row), 32'(got.row));
            check_field("cell_data", 32'(want.cell_word), 32'(got.cell_word));
            check_field("did_scroll", 32'(want.scrolled), 32'(got.scrolled));
         end
      end
   end

   initial begin : stimulus
      logic [1:0]     kind;
      logic [7:0]     ch;
      logic [7:0]     c;
      logic [7:0]     r;
      logic [CSR_DW-1:0] fg_word;
      logic [CSR_DW-1:0] bg_word;
      for (int i = 0; i < NCELLS; i++)
         screen_img[i] = BLANK_CELL;
      cur_x = 0;
      cur_y = RESET_ROW;
      ink_fg = FG_RESET;
      ink_bg = BG_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < NSTEPS; s++)
         push_request(SCRIPT[s].kind, SCRIPT[s].ch, SCRIPT[s].c, SCRIPT[s].r,
                      SCRIPT[s].typed, SCRIPT[s].want);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               fg_word = 32'hFFFF_FFFF;
               bg_word = 32'hFFFF_FFFF;
            end
            1: begin
               // upper bits must be dropped
               fg_word = 32'hFFFF_FFF0;
               bg_word = 32'h0000_0010;
            end
            default: begin
               fg_word = $urandom;
               bg_word = $urandom;
            end
         endcase
         csr_write(CSR_FG_ADDR, fg_word);
         csr_write(CSR_BG_ADDR, bg_word);
         gaps_on = (phase != 2);
         repeat (PHASE_ITEMS) begin
            random_request(kind, ch, c, r);
            push_request(kind, ch, c, r, PREDICTED, '0);
         end
         settle();
      end
      gaps_on = 1'b1;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
